// ===== design/ngft_pkg.sv =====
package ngft_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int MAX_GRAM_LEN  = 3;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int TOKEN_W       = 16;
  localparam int KEY_W         = 3 * TOKEN_W;

  localparam logic [15:0] WEIGHT_STEP  = 16'd328;
  localparam logic [15:0] WEIGHT_START = 16'd3277;
  localparam logic [15:0] WEIGHT_ONE   = 16'd32768;

  localparam logic [2:0] STATUS_HIT     = 3'd0;
  localparam logic [2:0] STATUS_INSERT  = 3'd1;
  localparam logic [2:0] STATUS_FULL    = 3'd2;
  localparam logic [2:0] STATUS_IGNORED = 3'd3;
  localparam logic [2:0] STATUS_DECAY   = 3'd4;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_DECAY  = 1'b1;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_AUTO   = 2'd1;
  localparam logic [1:0] MODE_FORCED = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] tokens;
    logic [1:0]       len;
    logic [15:0]      weight;
    logic [15:0]      freq;
    logic             alive;
  } entry_t;

  typedef struct packed {
    logic load_prev;
    logic load_next;
  } cell_ctl_t;

endpackage

// ===== design/ngram_frequency_table.sv =====
// N-gram frequency table.
// Input channel (in_valid / in_stall): one beat is either a record of one
// n-gram (opcode 0, tokens and gram_length) or a decay pass (opcode 1,
// decay_scale in Q1.15). Output channel (out_valid / out_stall): exactly one
// result beat per input beat, in order.
// The table lives in a ring of TABLE_ENTRIES cells that rotates by one slot
// each cycle during a pass; the head cell is compared, updated or replaced
// as it passes. A record takes one full rotation and then hands its result
// to the output; a record in mode off skips the ring. A decay takes three
// rotations: decay and mark, collect tail survivors onto a cell stack, then
// pop them into the holes.
// in_stall is high from the accepting edge until the result moves into the
// output register; the output register holds one finished beat, so the next
// item may be accepted while that beat still waits on out_stall.
// Reset (rst, synchronous) empties the table, clears the insert count,
// sets run_mode to automatic and drops any pending result. Table cells are
// not cleared: only slots below the live count are ever examined.
// The user writes run_mode through cfg_write_en / cfg_write_data only
// while idle; the block itself does not enforce this.
module ngram_frequency_table
  import ngft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [1:0]  gram_length,
  input  logic [15:0] token_0,
  input  logic [15:0] token_1,
  input  logic [15:0] token_2,
  input  logic [15:0] decay_scale,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  entry_index,
  output logic [15:0] entry_frequency,
  output logic [15:0] entry_weight,
  output logic [8:0]  live_entries,
  output logic [23:0] weight_sum,
  output logic [31:0] total_inserted
);

  typedef enum logic [2:0] {
    S_IDLE, S_REC, S_DECAY, S_COLLECT, S_FILL, S_DONE
  } state_t;

  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  state_t            state;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  live_count;
  logic [CNT_W-1:0]  keep_count;
  logic [CNT_W-1:0]  depth;
  logic [31:0]       insert_total;
  logic [1:0]        run_mode;
  logic [KEY_W-1:0]  key;
  logic [1:0]        key_len;
  logic [15:0]       rate;
  logic              hit;
  logic              ins;
  logic [23:0]       sum;

  logic [2:0]        res_status;
  logic [7:0]        res_index;
  logic [15:0]       res_freq;
  logic [15:0]       res_weight;
  logic [8:0]        res_live;
  logic [23:0]       res_sum;
  logic [31:0]       res_total;

  entry_t            ring_q  [TABLE_ENTRIES];
  entry_t            stack_q [TABLE_ENTRIES];
  entry_t            head;
  entry_t            head_new;
  cell_ctl_t         ring_ctl;
  cell_ctl_t         stack_ctl;

  logic              hit_now;
  logic              ins_now;
  logic              push;
  logic              pop;
  logic              alive_now;
  logic [31:0]       prod;
  logic [16:0]       wsum;
  logic [24:0]       sum_wide;
  logic [1:0]        len_clamped;
  logic [KEY_W-1:0]  key_in;
  logic              at_end;

  // Clamp the length and mask unused tokens.
  always_comb begin
    len_clamped = gram_length;
    if (gram_length == 2'd0) begin
      len_clamped = 2'd1;
    end else if (gram_length > 2'(MAX_GRAM_LEN)) begin
      len_clamped = 2'(MAX_GRAM_LEN);
    end
    key_in = '0;
    key_in[TOKEN_W-1:0] = token_0;
    if (len_clamped >= 2'd2) begin
      key_in[2*TOKEN_W-1:TOKEN_W] = token_1;
    end
    if (len_clamped >= 2'd3) begin
      key_in[3*TOKEN_W-1:2*TOKEN_W] = token_2;
    end
  end

  assign head   = ring_q[0];
  assign at_end = (pos == LAST_POS);

  // Head cell processing: what goes back into the tail of the ring.
  always_comb begin
    head_new  = head;
    hit_now   = 1'b0;
    ins_now   = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    alive_now = 1'b0;
    prod      = 32'(head.weight) * 32'(rate);
    wsum      = 17'(head.weight) + 17'(WEIGHT_STEP);
    sum_wide  = 25'(sum) + 25'(prod[30:15]);
    unique case (state)
      S_REC: begin
        if (pos < live_count && !hit && head.len == key_len && head.tokens == key) begin
          hit_now = 1'b1;
          head_new.weight = (wsum > 17'(WEIGHT_ONE)) ? WEIGHT_ONE : wsum[15:0];
          if (head.freq != 16'hFFFF) begin
            head_new.freq = head.freq + 16'd1;
          end
        end else if (pos == live_count && !hit) begin
          ins_now = 1'b1;
          head_new.tokens = key;
          head_new.len    = key_len;
          head_new.weight = WEIGHT_START;
          head_new.freq   = 16'd1;
          head_new.alive  = 1'b0;
        end
      end
      S_DECAY: begin
        if (pos < live_count) begin
          head_new.weight = prod[30:15];
          alive_now = (prod[30:15] >= WEIGHT_STEP);
        end
        head_new.alive = alive_now;
      end
      S_COLLECT: begin
        push = (pos >= keep_count) && (pos < live_count) && head.alive;
      end
      S_FILL: begin
        pop = (pos < keep_count) && !head.alive;
        if (pop) begin
          head_new = stack_q[0];
          head_new.alive = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ring_ctl.load_prev  = 1'b0;
  assign ring_ctl.load_next  = (state == S_REC) || (state == S_DECAY) ||
                               (state == S_COLLECT) || (state == S_FILL);
  assign stack_ctl.load_prev = push;
  assign stack_ctl.load_next = pop;

  // Ring: each cell takes its right neighbor; the tail takes the head result.
  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_ring
    ngft_cell u_cell (
      .clk      (clk),
      .ctl      (ring_ctl),
      .din_prev ((k == 0) ? head_new : ring_q[(k + TABLE_ENTRIES - 1) % TABLE_ENTRIES]),
      .din_next ((k == TABLE_ENTRIES - 1) ? head_new : ring_q[(k + 1) % TABLE_ENTRIES]),
      .q        (ring_q[k])
    );
  end

  // Stack: push shifts away from the top, pop shifts toward it.
  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_stack
    ngft_cell u_cell (
      .clk      (clk),
      .ctl      (stack_ctl),
      .din_prev ((k == 0) ? head : stack_q[(k + TABLE_ENTRIES - 1) % TABLE_ENTRIES]),
      .din_next ((k == TABLE_ENTRIES - 1) ? stack_q[k] : stack_q[(k + 1) % TABLE_ENTRIES]),
      .q        (stack_q[k])
    );
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      live_count   <= '0;
      insert_total <= '0;
      run_mode     <= MODE_AUTO;
      out_valid    <= 1'b0;
      depth        <= '0;
    end else begin
      if (cfg_write_en) begin
        run_mode <= cfg_write_data;
      end
      // Drop the taken beat unless a new one loads in its place.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (push) begin
        depth <= depth + CNT_W'(1);
      end else if (pop) begin
        depth <= depth - CNT_W'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pos        <= '0;
            hit        <= 1'b0;
            ins        <= 1'b0;
            sum        <= '0;
            keep_count <= '0;
            key        <= key_in;
            key_len    <= len_clamped;
            rate       <= (decay_scale > WEIGHT_ONE) ? WEIGHT_ONE : decay_scale;
            res_index  <= '0;
            res_freq   <= '0;
            res_weight <= '0;
            res_sum    <= '0;
            res_live   <= 9'(live_count);
            res_total  <= insert_total;
            if (opcode == OP_DECAY) begin
              state <= S_DECAY;
            end else if (run_mode == MODE_OFF) begin
              res_status <= STATUS_IGNORED;
              state      <= S_DONE;
            end else begin
              state <= S_REC;
            end
          end
        end
        S_REC: begin
          pos <= pos + CNT_W'(1);
          if (hit_now) begin
            hit        <= 1'b1;
            res_index  <= 8'(pos);
            res_freq   <= head_new.freq;
            res_weight <= head_new.weight;
          end
          if (ins_now) begin
            ins        <= 1'b1;
            res_index  <= 8'(pos);
            res_freq   <= head_new.freq;
            res_weight <= head_new.weight;
          end
          if (at_end) begin
            state <= S_DONE;
            priority if (hit || hit_now) begin
              res_status <= STATUS_HIT;
            end else if (ins || ins_now) begin
              res_status <= STATUS_INSERT;
              live_count <= live_count + CNT_W'(1);
              res_live   <= 9'(live_count + CNT_W'(1));
              if (insert_total != 32'hFFFF_FFFF) begin
                insert_total <= insert_total + 32'd1;
                res_total    <= insert_total + 32'd1;
              end
            end else begin
              res_status <= STATUS_FULL;
            end
          end
        end
        S_DECAY: begin
          if (pos < live_count && alive_now) begin
            sum        <= sum_wide[24] ? 24'hFF_FFFF : sum_wide[23:0];
            keep_count <= keep_count + CNT_W'(1);
          end
          if (at_end) begin
            pos   <= '0;
            state <= S_COLLECT;
          end else begin
            pos <= pos + CNT_W'(1);
          end
        end
        S_COLLECT: begin
          if (at_end) begin
            pos   <= '0;
            state <= S_FILL;
          end else begin
            pos <= pos + CNT_W'(1);
          end
        end
        S_FILL: begin
          pos <= pos + CNT_W'(1);
          if (at_end) begin
            live_count <= keep_count;
            res_status <= STATUS_DECAY;
            res_live   <= 9'(keep_count);
            res_sum    <= sum;
            res_total  <= '0;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            entry_index     <= res_index;
            entry_frequency <= res_freq;
            entry_weight    <= res_weight;
            live_entries    <= res_live;
            weight_sum      <= res_sum;
            total_inserted  <= res_total;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= FULL_CNT) else $error("live count beyond table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE)) else $error("accepted beat not worked");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(push && pop)) else $error("stack push and pop together");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (depth != '0)) else $error("pop from empty stack");

  a_stack_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && at_end) |-> (depth == CNT_W'(pop)))
    else $error("survivors left on stack after fill");
`endif

endmodule

// ===== design/ngft_cell.sv =====
module ngft_cell
  import ngft_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    din_prev,
  input  entry_t    din_next,
  output entry_t    q
);

  // Take from the left neighbor, from the right neighbor, or hold.
  always_ff @(posedge clk) begin
    if (ctl.load_prev) begin
      q <= din_prev;
    end else if (ctl.load_next) begin
      q <= din_next;
    end
  end

endmodule

// ===== test/ngram_frequency_table_checker.sv =====
module ngram_frequency_table_checker
  import ngft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_write_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        opcode,
  input  logic [1:0]  gram_length,
  input  logic [15:0] token_0,
  input  logic [15:0] token_1,
  input  logic [15:0] token_2,
  input  logic [15:0] decay_scale,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [7:0]  entry_index,
  input  logic [15:0] entry_frequency,
  input  logic [15:0] entry_weight,
  input  logic [8:0]  live_entries,
  input  logic [23:0] weight_sum,
  input  logic [31:0] total_inserted,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  index;
    logic [15:0] freq;
    logic [15:0] weight;
    logic [8:0]  live;
    logic [23:0] wsum;
    logic [31:0] inserted;
  } table_reply_t;

  logic [KEY_W-1:0] key_tab[TABLE_ENTRIES];
  logic [1:0]       len_tab[TABLE_ENTRIES];
  logic [15:0]      wt_tab[TABLE_ENTRIES];
  logic [15:0]      frq_tab[TABLE_ENTRIES];
  int               live_n;
  logic [31:0]      ins_total;
  logic [1:0]       mode;

  table_reply_t reply_q[$];
  int mismatches;

  assign fail_count = mismatches + reply_q.size();

  function automatic table_reply_t table_apply(logic op, logic [1:0] glen, logic [15:0] t0,
                                               logic [15:0] t1, logic [15:0] t2,
                                               logic [15:0] rate_in);
    table_reply_t r;
    logic [KEY_W-1:0] key;
    logic [1:0] len;
    logic [31:0] w;
    logic [31:0] rate;
    logic [31:0] sum;
    int i;
    r = '0;
    if (op == OP_DECAY) begin
      rate = (rate_in > WEIGHT_ONE) ? 32'(WEIGHT_ONE) : 32'(rate_in);
      sum = 0;
      i = 0;
      while (i < live_n) begin
        w = (32'(wt_tab[i]) * rate) >> 15;
        wt_tab[i] = w[15:0];
        if (w < 32'(WEIGHT_STEP)) begin
          // fill the hole from the tail, then revisit the same slot
          if (i < live_n - 1) begin
            key_tab[i] = key_tab[live_n-1];
            len_tab[i] = len_tab[live_n-1];
            wt_tab[i]  = wt_tab[live_n-1];
            frq_tab[i] = frq_tab[live_n-1];
          end
          live_n--;
        end else begin
          sum += w;
          if (sum > 32'hFFFFFF) sum = 32'hFFFFFF;
          i++;
        end
      end
      r.status = STATUS_DECAY;
      r.live = 9'(live_n);
      r.wsum = sum[23:0];
      return r;
    end
    if (mode == MODE_OFF) begin
      r.status = STATUS_IGNORED;
      r.live = 9'(live_n);
      r.inserted = ins_total;
      return r;
    end
    len = (glen == 2'd0) ? 2'd1 : glen;
    key = '0;
    key[15:0] = t0;
    if (len >= 2'd2) key[31:16] = t1;
    if (len == 2'd3) key[47:32] = t2;
    for (i = 0; i < live_n; i++) begin
      if (len_tab[i] == len && key_tab[i] == key) begin
        w = 32'(wt_tab[i]) + 32'(WEIGHT_STEP);
        if (w > 32'(WEIGHT_ONE)) w = 32'(WEIGHT_ONE);
        wt_tab[i] = w[15:0];
        if (frq_tab[i] != 16'hFFFF) frq_tab[i]++;
        r.status = STATUS_HIT;
        r.index = 8'(i);
        r.freq = frq_tab[i];
        r.weight = wt_tab[i];
        r.live = 9'(live_n);
        r.inserted = ins_total;
        return r;
      end
    end
    if (live_n < TABLE_ENTRIES) begin
      key_tab[live_n] = key;
      len_tab[live_n] = len;
      wt_tab[live_n] = WEIGHT_START;
      frq_tab[live_n] = 16'd1;
      r.status = STATUS_INSERT;
      r.index = 8'(live_n);
      r.freq = 16'd1;
      r.weight = WEIGHT_START;
      live_n++;
      if (ins_total != 32'hFFFFFFFF) ins_total++;
    end else begin
      r.status = STATUS_FULL;
    end
    r.live = 9'(live_n);
    r.inserted = ins_total;
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    table_reply_t want;
    if (rst) begin
      live_n = 0;
      ins_total = '0;
      mode = MODE_AUTO;
      reply_q.delete();
      mismatches = 0;
    end else begin
      // the block samples the mode held before this edge
      if (in_valid && !in_stall)
        reply_q.push_back(table_apply(opcode, gram_length, token_0, token_1, token_2,
                                      decay_scale));
      if (cfg_write_en) mode = cfg_write_data;
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none actual status %0d",
                   $time, status);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          check_field("status", want.status, status);
          check_field("entry_index", want.index, entry_index);
          check_field("entry_frequency", want.freq, entry_frequency);
          check_field("entry_weight", want.weight, entry_weight);
          check_field("live_entries", want.live, live_entries);
          check_field("weight_sum", want.wsum, weight_sum);
          check_field("total_inserted", want.inserted, total_inserted);
        end
      end
    end
  end

endmodule

// ===== test/ngram_frequency_table_tb.sv =====
module ngram_frequency_table_tb
  import ngft_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Worst case is every item a full decay plus stalls.
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int HOT_GRAMS   = 12;

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic [1:0]  cfg_write_data;
  logic        in_valid;
  logic        in_stall;
  logic        opcode;
  logic [1:0]  gram_length;
  logic [15:0] token_0, token_1, token_2, decay_scale;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [7:0]  entry_index;
  logic [15:0] entry_frequency, entry_weight;
  logic [8:0]  live_entries;
  logic [23:0] weight_sum;
  logic [31:0] total_inserted;
  int          fail_count;

  int sent_beats;
  int got_beats;
  bit quiet_tail;   // no idling on either side near the end
  bit long_hold;    // ask the receiver for one long hold-off
  int cycles;

  logic [1:0]  hot_len[HOT_GRAMS];
  logic [15:0] hot_tok[HOT_GRAMS][3];

  ngram_frequency_table dut (.*);

  ngram_frequency_table_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Count result beats taken by the receiver.
  always @(posedge clk) begin
    if (rst) got_beats <= 0;
    else if (out_valid && !out_stall) got_beats <= got_beats + 1;
  end

  // Receiver: random stall/run bursts, one assignment per burst; one long hold; a stall-free tail.
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        // hold long enough for the block to finish one item and block its input
        out_stall <= 1'b1;
        for (n = 0; n < 3000; n++) @(posedge clk);
        long_hold = 0;
      end else if (quiet_tail) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Offer one beat and hold it until the block takes it.
  task automatic send_item(logic op, logic [1:0] glen, logic [15:0] t0, logic [15:0] t1,
                           logic [15:0] t2, logic [15:0] rate);
    if (!quiet_tail && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    gram_length <= glen;
    token_0     <= t0;
    token_1     <= t1;
    token_2     <= t2;
    decay_scale <= rate;
    do @(posedge clk); while (in_stall);
    sent_beats++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (got_beats != sent_beats) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= m;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    @(posedge clk);
  endtask

  // One random item: mostly records, half of them on a small hot set so
  // weights climb to saturation; decays half gentle, some at any rate, a few harsh.
  task automatic random_item();
    int h;
    int pick;
    logic [15:0] rate;
    if ($urandom_range(0, 99) < 8) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)      rate = 16'($urandom_range(31000, 32768));
      else if (pick < 8) rate = 16'($urandom_range(0, 65535));
      else               rate = 16'($urandom_range(0, 20000));
      send_item(OP_DECAY, 2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), rate);
    end else if ($urandom_range(0, 1) == 0) begin
      h = $urandom_range(0, HOT_GRAMS - 1);
      // tokens past the length are don't-care, so scramble them
      send_item(OP_RECORD, hot_len[h], hot_tok[h][0],
                hot_len[h] >= 2 ? hot_tok[h][1] : 16'($urandom),
                hot_len[h] == 3 ? hot_tok[h][2] : 16'($urandom), 16'($urandom));
    end else begin
      send_item(OP_RECORD, 2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    end
  endtask

  initial begin
    int i;
    int k;
    logic [1:0] modes[4];
    int counts[4];
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    in_valid = 1'b0;
    opcode = OP_RECORD;
    gram_length = '0;
    token_0 = '0;
    token_1 = '0;
    token_2 = '0;
    decay_scale = '0;
    sent_beats = 0;
    quiet_tail = 0;
    long_hold = 0;
    for (i = 0; i < HOT_GRAMS; i++) begin
      hot_len[i] = 2'($urandom_range(1, 3));
      for (k = 0; k < 3; k++) hot_tok[i][k] = 16'($urandom);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: decay on empty table, length zero, field extremes, hits.
    send_item(OP_DECAY, 2'd0, 16'd0, 16'd0, 16'd0, 16'd32768);
    send_item(OP_RECORD, 2'd0, 16'hFFFF, 16'h1234, 16'h5678, 16'd0);
    send_item(OP_RECORD, 2'd1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);  // hit on length 0 entry
    send_item(OP_RECORD, 2'd1, 16'h0000, 16'h0000, 16'h0000, 16'd0);
    send_item(OP_RECORD, 2'd2, 16'h0000, 16'h0000, 16'hAAAA, 16'd0);
    send_item(OP_RECORD, 2'd3, 16'h0000, 16'h0000, 16'h0000, 16'd0);
    send_item(OP_RECORD, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    send_item(OP_RECORD, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    send_item(OP_RECORD, 2'd2, 16'h0000, 16'h0000, 16'h5555, 16'd0);
    send_item(OP_DECAY, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);   // rate above 1.0
    send_item(OP_DECAY, 2'd0, 16'd0, 16'd0, 16'd0, 16'd32768);
    send_item(OP_DECAY, 2'd0, 16'd0, 16'd0, 16'd0, 16'd3200);            // drop fresh entries
    send_item(OP_RECORD, 2'd1, 16'h00FF, 16'd0, 16'd0, 16'd0);
    send_item(OP_DECAY, 2'd0, 16'd0, 16'd0, 16'd0, 16'd0);               // wipe the table
    send_item(OP_RECORD, 2'd1, 16'h7FFF, 16'd0, 16'd0, 16'd0);
    drain();
    // Mode off: records ignored, decay still runs.
    set_mode(MODE_OFF);
    send_item(OP_RECORD, 2'd2, 16'h1111, 16'h2222, 16'd0, 16'd0);
    send_item(OP_DECAY, 2'd0, 16'd0, 16'd0, 16'd0, 16'd32000);
    send_item(OP_RECORD, 2'd1, 16'h7FFF, 16'd0, 16'd0, 16'd0);
    drain();
    // Unused mode code acts as automatic.
    set_mode(MODE_SPARE);
    send_item(OP_RECORD, 2'd1, 16'h7FFF, 16'd0, 16'd0, 16'd0);
    send_item(OP_RECORD, 2'd2, 16'h1111, 16'h2222, 16'd0, 16'd0);
    drain();

    // Random phases over every mode; pause for a full drain between them.
    modes  = '{MODE_FORCED, MODE_OFF, MODE_AUTO, MODE_SPARE};
    counts = '{600, 120, 700, 410};
    for (k = 0; k < 4; k++) begin
      set_mode(modes[k]);
      for (i = 0; i < counts[k]; i++) begin
        if (k == 2 && i == 300) long_hold = 1;
        if (k == 3 && i == counts[k] - 150) quiet_tail = 1;
        random_item();
      end
      drain();
    end

    repeat (800) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ngft_pkg.sv
design/ngft_cell.sv
design/ngram_frequency_table.sv
test/ngram_frequency_table_checker.sv
test/ngram_frequency_table_tb.sv
